/* rtl/ssr_pkg.sv */
// ssr_pkg: shared types, step codes and control store for the substring replacer
// used by ssr_window and stream_substring_replace; no dependencies
package ssr_pkg;

  // step addresses of the control program
  localparam logic [2:0] PC_LOAD  = 3'd0;
  localparam logic [2:0] PC_SCAN  = 3'd1;
  localparam logic [2:0] PC_REPL  = 3'd2;
  localparam logic [2:0] PC_FLUSH = 3'd3;
  localparam logic [2:0] PC_CLOSE = 3'd4;

  // datapath operations
  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_SCAN  = 3'd1;
  localparam logic [2:0] OP_REPL  = 3'd2;
  localparam logic [2:0] OP_FLUSH = 3'd3;
  localparam logic [2:0] OP_CLOSE = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_PATTERN  = 3'd0;
  localparam logic [2:0] REG_SLEN     = 3'd1;
  localparam logic [2:0] REG_REPTEXT  = 3'd2;
  localparam logic [2:0] REG_RLEN     = 3'd3;

  // one control word: operation, primary exit, secondary exit
  typedef struct packed {
    logic [2:0] op;
    logic [2:0] tgt_a;
    logic [2:0] tgt_b;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic clr;
  } win_ctl_t;

  typedef struct packed {
    logic full;   // window equals the whole pattern
    logic part;   // window is a proper prefix of the pattern, or empty
    logic empty;
  } win_stat_t;

  function automatic ucode_t ucode_rom(input logic [2:0] pc);
    ucode_t w;
    case (pc)
      PC_LOAD:  w = '{op: OP_LOAD,  tgt_a: PC_SCAN,  tgt_b: PC_SCAN};
      PC_SCAN:  w = '{op: OP_SCAN,  tgt_a: PC_REPL,  tgt_b: PC_FLUSH};
      PC_REPL:  w = '{op: OP_REPL,  tgt_a: PC_FLUSH, tgt_b: PC_FLUSH};
      PC_FLUSH: w = '{op: OP_FLUSH, tgt_a: PC_CLOSE, tgt_b: PC_CLOSE};
      PC_CLOSE: w = '{op: OP_CLOSE, tgt_a: PC_LOAD,  tgt_b: PC_LOAD};
      default:  w = '{op: OP_LOAD,  tgt_a: PC_LOAD,  tgt_b: PC_LOAD};
    endcase
    return w;
  endfunction

endpackage

/* rtl/ssr_window.sv */
// ssr_window: held-byte window with prefix compare against the search pattern
// depends on ssr_pkg for the control and status structs
module ssr_window import ssr_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 8,
  localparam int unsigned CW = $clog2(MAX_PATTERN + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  win_ctl_t      ctl_i,
  input  logic [7:0]    byte_i,
  input  logic [63:0]   pattern_i,
  input  logic [CW-1:0] plen_i,
  output logic [7:0]    head_o,
  output win_stat_t     stat_o
);

  localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [7:0]             win_q [MAX_PATTERN];
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [MAX_PATTERN-1:0] hit;
  logic                   prefix_ok;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      hit[i] = (CW'(i) >= cnt_q) || (win_q[i] == pattern_i[8*i +: 8]);
    end
    prefix_ok = &hit;
  end

  assign head_o       = win_q[0];
  assign stat_o.full  = prefix_ok && (cnt_q == plen_i);
  assign stat_o.part  = prefix_ok && (cnt_q < plen_i);
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.clr) begin
      cnt_d = '0;
    end else if (ctl_i.load) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ctl_i.shift) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // new byte lands behind the held ones; a shift drops the oldest
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      win_q[cnt_q[IW-1:0]] <= byte_i;
    end else if (ctl_i.shift) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
    end
  end

endmodule

/* rtl/stream_substring_replace.sv */
// stream_substring_replace: top level, control store sequencer and output stage
// depends on ssr_pkg and ssr_window
//
// Streaming find-and-replace-all over bytes. Source bytes enter on the s_axis
// channel, one beat per byte, tlast marking the final byte of a text. The
// rewritten text leaves on m_axis, one byte per beat; tlast closes the beats
// caused by one input byte, tuser[1] closes the whole text and tuser[0] is low
// only on the empty end marker of a text that produced nothing at its end.
// The cfg channel (always ready) writes pattern, pattern length, replacement
// and replacement length; write it only while the block is idle. A pattern or
// pattern-length write drops any held bytes.
// One input byte is handled at a time by a five-step control program: load,
// scan, replace (only on a match, releasing the replacement), flush and
// close. Each released byte waits in a pending register until the next
// byte or the close step, so its end flags are known.
// Reset clears the held bytes and loads the register defaults. When m_axis
// stalls the program waits on the step that needs to push a beat; one
// finished beat sits in the output register meanwhile.
module stream_substring_replace import ssr_pkg::*; #(
  parameter int unsigned MAX_PATTERN     = 8,
  parameter int unsigned MAX_REPLACEMENT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,   // run_end
  output logic [1:0]  m_axis_tuser,   // [0] byte_present, [1] text_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);

  // configuration registers
  logic [63:0] pattern_q, reptext_q;
  logic [3:0]  slen_q, rlen_q;

  // sequencer state
  logic [2:0] pc_q, pc_d;
  logic       fin_q, fin_d;
  logic       pend_v_q, pend_v_d;
  logic [7:0] pend_b_q, pend_b_d;
  logic [3:0] ridx_q, ridx_d;

  // output register
  logic       out_v_q, out_v_d;
  logic [7:0] out_b_q, out_b_d;
  logic       out_last_q, out_last_d;
  logic       out_pres_q, out_pres_d;
  logic       out_tend_q, out_tend_d;

  ucode_t     uw;
  win_ctl_t   seq_ctl, win_ctl;
  win_stat_t  wstat;
  logic [7:0] head;
  logic [CW-1:0] plen;
  logic [3:0] rlen;
  logic       out_free, emit_ok, emit_en, cfg_wr, cfg_clr;
  logic [7:0] emit_b;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_clr     = cfg_wr && ((cfg_index_i == REG_PATTERN) || (cfg_index_i == REG_SLEN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      slen_q    <= 4'd1;
      reptext_q <= '0;
      rlen_q    <= '0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_PATTERN: pattern_q <= cfg_data_i;
        REG_SLEN:    slen_q    <= cfg_data_i[3:0];
        REG_REPTEXT: reptext_q <= cfg_data_i;
        REG_RLEN:    rlen_q    <= cfg_data_i[3:0];
        default:     ;
      endcase
    end
  end

  // length clamps
  always_comb begin
    if (slen_q == '0) begin
      plen = CW'(1);
    end else if (slen_q > 4'(MAX_PATTERN)) begin
      plen = CW'(MAX_PATTERN);
    end else begin
      plen = CW'(slen_q);
    end
    rlen = (rlen_q > 4'(MAX_REPLACEMENT)) ? 4'(MAX_REPLACEMENT) : rlen_q;
  end

  assign win_ctl = '{load: seq_ctl.load, shift: seq_ctl.shift, clr: seq_ctl.clr | cfg_clr};

  ssr_window #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (win_ctl),
    .byte_i    (s_axis_tdata),
    .pattern_i (pattern_q),
    .plen_i    (plen),
    .head_o    (head),
    .stat_o    (wstat)
  );

  assign uw       = ucode_rom(pc_q);
  assign out_free = !out_v_q || m_axis_tready;
  // a new byte only needs the output slot when one is already pending
  assign emit_ok  = !pend_v_q || out_free;

  always_comb begin
    pc_d          = pc_q;
    fin_d         = fin_q;
    pend_v_d      = pend_v_q;
    pend_b_d      = pend_b_q;
    ridx_d        = ridx_q;
    out_v_d       = out_v_q && !m_axis_tready;
    out_b_d       = out_b_q;
    out_last_d    = out_last_q;
    out_pres_d    = out_pres_q;
    out_tend_d    = out_tend_q;
    seq_ctl       = '0;
    s_axis_tready = 1'b0;
    emit_en       = 1'b0;
    emit_b        = head;

    case (uw.op)
      OP_LOAD: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          seq_ctl.load = 1'b1;
          fin_d        = s_axis_tlast;
          pc_d         = uw.tgt_a;
        end
      end
      OP_SCAN: begin
        if (wstat.full) begin
          ridx_d = '0;
          pc_d   = uw.tgt_a;
        end else if (wstat.part) begin
          pc_d = uw.tgt_b;
        end else if (emit_ok) begin
          emit_en       = 1'b1;
          seq_ctl.shift = 1'b1;
        end
      end
      OP_REPL: begin
        if (ridx_q == rlen) begin
          seq_ctl.clr = 1'b1;
          pc_d        = uw.tgt_a;
        end else if (emit_ok) begin
          emit_en = 1'b1;
          emit_b  = reptext_q[{ridx_q[2:0], 3'b000} +: 8];
          ridx_d  = ridx_q + 4'd1;
        end
      end
      OP_FLUSH: begin
        if (fin_q && !wstat.empty) begin
          if (emit_ok) begin
            emit_en       = 1'b1;
            seq_ctl.shift = 1'b1;
          end
        end else begin
          pc_d = uw.tgt_a;
        end
      end
      OP_CLOSE: begin
        if (pend_v_q || fin_q) begin
          if (out_free) begin
            out_v_d    = 1'b1;
            out_b_d    = pend_v_q ? pend_b_q : 8'h00;
            out_pres_d = pend_v_q;
            out_last_d = 1'b1;
            out_tend_d = fin_q;
            pend_v_d   = 1'b0;
            pc_d       = uw.tgt_a;
          end
        end else begin
          pc_d = uw.tgt_a;
        end
      end
      default: pc_d = PC_LOAD;
    endcase

    // the previous byte is known not to be last once another one follows
    if (emit_en) begin
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_b_d    = pend_b_q;
        out_pres_d = 1'b1;
        out_last_d = 1'b0;
        out_tend_d = 1'b0;
      end
      pend_v_d = 1'b1;
      pend_b_d = emit_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= PC_LOAD;
      fin_q    <= 1'b0;
      pend_v_q <= 1'b0;
      ridx_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      pc_q     <= pc_d;
      fin_q    <= fin_d;
      pend_v_q <= pend_v_d;
      ridx_q   <= ridx_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_b_q   <= pend_b_d;
    out_b_q    <= out_b_d;
    out_last_q <= out_last_d;
    out_pres_q <= out_pres_d;
    out_tend_q <= out_tend_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_b_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_tend_q, out_pres_q};

endmodule

/* rtl/ssr_checker.sv */
// ssr_checker: port-level assertions for stream_substring_replace, with bind
// sees only the top-level ports; no package needed
module ssr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  // a stalled output beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // the empty marker only closes a text
  a_marker_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tuser[1]
      && (m_axis_tdata == 8'h00))
    else $error("empty marker not at end of text");

  // end of text is always end of a run
  a_text_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("text end without run end");

  // one input byte is worked on at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

/* sim/tb_stream_substring_replace.sv */
// tb_stream_substring_replace: self-checking bench for the streaming find-and-replace block
// depends on ssr_pkg and stream_substring_replace; predicts every output beat in-house
// directed corner cases, then random texts under several register settings and stalls, then a long output stall
module tb_stream_substring_replace import ssr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAT       = 8;
  localparam int MAX_REP       = 8;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int ROUNDS        = 8;
  localparam int ROUND_BYTES   = 36;
  localparam int PRINT_CAP     = 30;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       run_end;
    logic       text_end;
  } out_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // text_byte
  logic        s_axis_tlast;   // final_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // out_byte
  logic        m_axis_tlast;   // run_end
  logic [1:0]  m_axis_tuser;   // [0] byte_present, [1] text_end
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  // predictor state
  logic [63:0] cur_pattern = '0;
  logic [3:0]  cur_slen    = 4'd1;
  logic [63:0] rep_text    = '0;
  logic [3:0]  rep_len     = 4'd0;
  logic [55:0] held_vec    = '0;
  int          held_cnt    = 0;
  out_beat_t   expected_beats [$];

  int error_count  = 0;
  int bytes_sent   = 0;
  int beats_seen   = 0;
  int cfg_writes   = 0;
  int cycle_count  = 0;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  int rx_hold_req  = 0;

  stream_substring_replace u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pat_len_eff();
    if (cur_slen == 0) return 1;
    if (cur_slen > MAX_PAT) return MAX_PAT;
    return int'(cur_slen);
  endfunction

  function automatic bit prefix_ok(input logic [71:0] win, input int n);
    for (int i = 0; i < n; i++) begin
      if (win[8*i +: 8] != cur_pattern[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_CAP) $display("ERROR @%0t: %s", $time, what);
  endtask

  // window = held bytes plus the new one; release from the front until it is a prefix
  task automatic predict_rewrite(input logic [7:0] b, input logic fin);
    logic [71:0] win;
    logic [7:0]  emit [$];
    int          n;
    int          plen;
    int          rlen;
    out_beat_t   beat;
    win = {16'h0, held_vec};
    n = held_cnt;
    win[8*n +: 8] = b;
    n++;
    plen = pat_len_eff();
    rlen = (rep_len > MAX_REP) ? MAX_REP : rep_len;
    while (n > 0) begin
      if (n == plen && prefix_ok(win, n)) begin
        for (int i = 0; i < rlen; i++) emit.push_back(rep_text[8*i +: 8]);
        n = 0;
        break;
      end
      if (n < plen && prefix_ok(win, n)) break;
      emit.push_back(win[7:0]);
      win = win >> 8;
      n--;
    end
    if (fin) begin
      for (int i = 0; i < n; i++) emit.push_back(win[8*i +: 8]);
      n = 0;
    end
    held_vec = win[55:0];
    held_cnt = n;
    if (emit.size() == 0 && fin) begin
      beat = '{data: 8'h00, present: 1'b0, run_end: 1'b1, text_end: 1'b1};
      expected_beats.push_back(beat);
    end
    foreach (emit[i]) begin
      beat.data     = emit[i];
      beat.present  = 1'b1;
      beat.run_end  = (i == emit.size() - 1);
      beat.text_end = (i == emit.size() - 1) && fin;
      expected_beats.push_back(beat);
    end
  endtask

  task automatic check_beat();
    out_beat_t got;
    out_beat_t want;
    got = '{data: m_axis_tdata, present: m_axis_tuser[0], run_end: m_axis_tlast,
            text_end: m_axis_tuser[1]};
    beats_seen++;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat byte %02h present %b run_end %b text_end %b",
                                got.data, got.present, got.run_end, got.text_end));
      return;
    end
    want = expected_beats.pop_front();
    if (got.data !== want.data || got.present !== want.present ||
        got.run_end !== want.run_end || got.text_end !== want.text_end) begin
      report_mismatch($sformatf("beat %0d: got %02h/%b/%b/%b want %02h/%b/%b/%b", beats_seen,
                                got.data, got.present, got.run_end, got.text_end,
                                want.data, want.present, want.run_end, want.text_end));
    end
  endtask

  // output side: checks each beat, stalls at random or for a requested hold-off
  initial begin : result_checker
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_beat();
      if (rx_hold_req > 0) begin
        stall_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        m_axis_tready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i) cycle_count++;
    $display("timeout after %0d cycles", cycle_count);
    $display("stream_substring_replace: mismatch");
    $finish;
  end

  // valid stays high after the beat so back-to-back bytes need no second drive
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = ($urandom_range(0, 99) < tx_gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_rewrite(b, fin);
    bytes_sent++;
  endtask

  // first byte from bits 7:0, final flag on the last one if asked
  task automatic send_word(input logic [63:0] w, input int n, input bit fin_last);
    for (int i = 0; i < n; i++) send_byte(w[8*i +: 8], fin_last && (i == n - 1));
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data,
                           input bit release_after);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_PATTERN: begin
        cur_pattern = data;
        held_cnt = 0;
      end
      REG_SLEN: begin
        cur_slen = data[3:0];
        held_cnt = 0;
      end
      REG_REPTEXT: rep_text = data;
      REG_RLEN:    rep_len = data[3:0];
      default: ;
    endcase
    cfg_writes++;
    if (release_after) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input logic [63:0] pat, input logic [63:0] slen,
                            input logic [63:0] rtext, input logic [63:0] rlen);
    cfg_write(REG_PATTERN, pat, 1'b0);
    cfg_write(REG_SLEN, slen, 1'b0);
    cfg_write(REG_REPTEXT, rtext, 1'b0);
    cfg_write(REG_RLEN, rlen, 1'b1);
  endtask

  // drain, then give a byte that releases nothing time to finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    // single zero byte pattern, empty replacement: zeros vanish
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // final byte that yields nothing gives the empty end marker
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_match_extremes();
    set_config(64'h00FF, 64'd2, 64'h8877_6655_4433_2211, 64'd8);
    send_word(64'h00FF, 2, 1'b0);
    // FF FF 00: first FF released, second starts the match
    send_word(64'h00_FFFF, 3, 1'b1);
    wait_idle();
    // seven held bytes then a miss releases eight beats
    set_config(64'h8070_6050_4030_2010, 64'd8, 64'h0, 64'd0);
    send_word(64'h0070_6050_4030_2010, 7, 1'b0);
    send_byte(8'h99, 1'b1);
    wait_idle();
  endtask

  task automatic test_length_clamp();
    // length nibble 0 acts as 1, replacement length 12 acts as 8
    set_config(64'h41, 64'hDEAD_BEEF_0000_00F0, 64'hA8A7_A6A5_A4A3_A2A1, 64'hFFFF_0000_0000_000C);
    send_byte(8'h41, 1'b1);
    wait_idle();
    // length 15 acts as 8, the pattern now ends in zero bytes
    cfg_write(REG_SLEN, 64'hF, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7E, 1'b1);
    wait_idle();
  endtask

  task automatic test_midtext_writes();
    logic [2:0] bad_idx;
    set_config(64'h6261, 64'd2, 64'h5A, 64'd1);
    send_byte(8'h61, 1'b0);
    wait_idle();
    // new pattern drops the held byte
    cfg_write(REG_PATTERN, 64'h7978, 1'b1);
    send_byte(8'h79, 1'b1);
    wait_idle();
    send_byte(8'h78, 1'b0);
    wait_idle();
    // replacement writes and unknown indexes keep the held byte
    cfg_write(REG_REPTEXT, 64'h3231, 1'b0);
    cfg_write(REG_RLEN, 64'd2, 1'b0);
    for (int k = REG_RLEN + 1; k < 8; k++) begin
      bad_idx = 3'(k);
      cfg_write(bad_idx, {$urandom(), $urandom()}, k == 7);
    end
    send_byte(8'h79, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_texts();
    logic [63:0] pat;
    logic [63:0] slen_word;
    logic [63:0] rlen_word;
    logic [7:0]  text [$];
    logic [7:0]  noise;
    int          plen;
    int          kind;
    int          cut;
    int          sent_at_start;
    for (int r = 0; r < ROUNDS; r++) begin
      // half the rounds use a two-letter alphabet so overlaps are common
      for (int i = 0; i < 8; i++) begin
        pat[8*i +: 8] = $urandom_range(0, 1) ? (8'h61 + 8'($urandom_range(0, 1)))
                                             : 8'($urandom_range(0, 255));
        if (r % 2 == 0) pat[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 1));
      end
      slen_word = {$urandom(), $urandom()};
      case (r)
        0:       slen_word[3:0] = 4'd1;
        1:       slen_word[3:0] = 4'd8;
        2:       slen_word[3:0] = 4'd0;
        3:       slen_word[3:0] = 4'hF;
        default: slen_word[3:0] = 4'($urandom_range(1, 8));
      endcase
      rlen_word = {$urandom(), $urandom()};
      case (r)
        0:       rlen_word[3:0] = 4'd0;
        1:       rlen_word[3:0] = 4'd8;
        4:       rlen_word[3:0] = 4'hB;
        default: rlen_word[3:0] = 4'($urandom_range(0, 8));
      endcase
      set_config(pat, slen_word, {$urandom(), $urandom()}, rlen_word);
      case (r % 3)
        0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_gap_pct = 25; rx_stall_pct = 25; end
        default: begin tx_gap_pct = 60; rx_stall_pct = 50; end
      endcase
      plen = pat_len_eff();
      sent_at_start = bytes_sent;
      while (bytes_sent - sent_at_start < ROUND_BYTES) begin
        // a text is whole patterns, broken prefixes and stray bytes
        text.delete();
        for (int s = $urandom_range(1, 12); s > 0; s--) begin
          kind = $urandom_range(0, 9);
          if (kind < 4) cut = plen;
          else if (kind < 6 && plen > 1) cut = $urandom_range(1, plen - 1);
          else cut = 0;
          for (int i = 0; i < cut; i++) text.push_back(cur_pattern[8*i +: 8]);
          if (cut == 0) begin
            noise = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 2) != 0) noise = cur_pattern[8*$urandom_range(0, plen - 1) +: 8];
            text.push_back(noise);
          end
        end
        foreach (text[i]) send_byte(text[i], i == text.size() - 1);
      end
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    logic [7:0] b;
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    set_config(64'h2A, 64'd1, {$urandom(), $urandom()}, 64'd8);
    // output held off while most bytes match and expand to eight beats
    rx_hold_req = 300;
    for (int i = 0; i < 40; i++) begin
      b = (i % 4 != 0) ? 8'h2A : 8'($urandom_range(0, 255));
      send_byte(b, i == 39);
    end
    wait_idle();
  endtask

  initial begin : main_seq
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_PATTERN;
    cfg_data_i    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    tx_gap_pct = 30;
    rx_stall_pct = 30;
    test_reset_defaults();
    test_match_extremes();
    test_length_clamp();
    test_midtext_writes();
    test_random_texts();
    test_backpressure();
    wait_idle();
    $display("sent %0d text bytes over %0d register writes, checked %0d output beats",
             bytes_sent, cfg_writes, beats_seen);
    $display("errors: %0d, cycles: %0d", error_count, cycle_count);
    if (error_count == 0) begin
      $display("stream_substring_replace: match");
    end else begin
      $display("stream_substring_replace: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ssr_pkg.sv
rtl/ssr_window.sv
rtl/stream_substring_replace.sv
rtl/ssr_checker.sv
sim/tb_stream_substring_replace.sv
